/* design/pkpe_pkg.sv */
package pkpe_pkg;

  localparam int unsigned NUM_ITEMS = 5;
  localparam logic [2:0] ITEM_LAST = 3'(NUM_ITEMS - 1);

  // Parameter item codes, shared by the selection and the set commands
  localparam logic [2:0] ITEM_CURRENT = 3'd0;
  localparam logic [2:0] ITEM_TRIGGER = 3'd1;
  localparam logic [2:0] ITEM_GAS     = 3'd2;
  localparam logic [2:0] ITEM_ARC     = 3'd3;
  localparam logic [2:0] ITEM_WORK    = 3'd4;

  localparam logic [1:0] WORK_MESH  = 2'd1;
  localparam logic [1:0] WORK_CLEAN = 2'd2;

  localparam logic [3:0] TIME_LO = 4'd3;
  localparam logic [3:0] TIME_HI = 4'd15;

  localparam logic [13:0] RD_TITLE       = 14'h0001;
  localparam logic [13:0] RD_MAIN        = 14'h0002;
  localparam logic [13:0] RD_MAIN_DIGITS = 14'h0004;
  localparam logic [13:0] RD_ROW0        = 14'h0010;
  localparam logic [13:0] RD_VAL0        = 14'h0200;

  localparam int unsigned MAX_CMDS = 4;

  typedef enum logic [2:0] {
    REG_CURRENT_MIN           = 3'd0,
    REG_CURRENT_MAX_HIGH_LINE = 3'd1,
    REG_CURRENT_MAX_LOW_LINE  = 3'd2,
    REG_CURRENT_MAX_LIMITED   = 3'd3,
    REG_LINE_IS_HIGH          = 3'd4,
    REG_DEBOUNCE_LIMIT        = 3'd5,
    REG_REPEAT_START          = 3'd6,
    REG_REPEAT_NEXT           = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic up_level;
    logic down_level;
    logic left_level;
    logic right_level;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  selected_item;
    logic [5:0]  current_amps;
    logic        trigger_four_step;
    logic [3:0]  post_gas_seconds;
    logic [3:0]  arc_seconds;
    logic [1:0]  work_kind;
    logic [13:0] redraw_mask;
    logic        cmd_valid;
    logic [2:0]  cmd_code;
    logic [5:0]  cmd_value;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [5:0] cur_min;
    logic [5:0] max_hi;
    logic [5:0] max_lo;
    logic [5:0] max_lim;
    logic       line_hi;
    logic [3:0] deb_lim;
    logic [7:0] rep_start;
    logic [7:0] rep_next;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cur_min: 6'd15, max_hi: 6'd55, max_lo: 6'd40, max_lim: 6'd30,
    line_hi: 1'b1, deb_lim: 4'd2, rep_start: 8'd18, rep_next: 8'd4
  };

  typedef struct packed {
    logic [2:0] sel;
    logic [5:0] amps;
    logic       trig;
    logic [3:0] gas;
    logic [3:0] arc;
    logic [1:0] work;
  } prm_t;

  localparam prm_t PRM_RESET = '{
    sel: ITEM_CURRENT, amps: 6'd55, trig: 1'b0, gas: 4'd5, arc: 4'd3, work: 2'd0
  };

  // Accumulated effect of one tick
  typedef struct packed {
    prm_t                          p;
    logic [13:0]                   mask;
    logic [2:0]                    ncmd;
    logic [MAX_CMDS-1:0][2:0]      codes;
    logic [MAX_CMDS-1:0][5:0]      vals;
  } tick_t;

  typedef struct packed {
    logic       held;
    logic [3:0] cnt;
    logic       fire;
  } deb_t;

  function automatic deb_t debounce(logic level, logic held, logic [3:0] cnt,
                                    logic [3:0] limit);
    deb_t r;
    r.held = held;
    r.cnt  = cnt;
    r.fire = 1'b0;
    if (level) begin
      r.held = 1'b0;
      r.cnt  = 4'd0;
    end else if (cnt < limit) begin
      r.cnt = cnt + 4'd1;
    end else if (!held) begin
      r.held = 1'b1;
      r.fire = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [5:0] ceiling(logic [1:0] work, cfg_t c);
    if (work == WORK_MESH || work == WORK_CLEAN) begin
      return c.max_lim;
    end
    return c.line_hi ? c.max_hi : c.max_lo;
  endfunction

  function automatic tick_t value_redraw(tick_t t, logic [2:0] item);
    tick_t r;
    r = t;
    r.mask = r.mask | (RD_VAL0 << item);
    if (r.p.sel == item) begin
      r.mask = r.mask | ((item == ITEM_WORK) ? RD_MAIN : RD_MAIN_DIGITS);
    end
    return r;
  endfunction

  function automatic tick_t issue(tick_t t, logic [2:0] code, logic [5:0] val);
    tick_t r;
    r = t;
    if (r.ncmd < 3'(MAX_CMDS)) begin
      r.codes[r.ncmd[1:0]] = code;
      r.vals[r.ncmd[1:0]]  = val;
      r.ncmd = r.ncmd + 3'd1;
    end
    return r;
  endfunction

  function automatic tick_t move_sel(tick_t t, logic fwd);
    tick_t      r;
    logic [2:0] old;
    r   = t;
    old = t.p.sel;
    if (fwd) begin
      r.p.sel = (old >= ITEM_LAST) ? ITEM_CURRENT : old + 3'd1;
    end else begin
      r.p.sel = (old == ITEM_CURRENT) ? ITEM_LAST : old - 3'd1;
    end
    r.mask = r.mask | RD_TITLE | RD_MAIN | (RD_ROW0 << old) | (RD_ROW0 << r.p.sel);
    return r;
  endfunction

  function automatic tick_t adjust(tick_t t, logic up, cfg_t c);
    tick_t      r;
    logic [5:0] ceil_v;
    r = t;
    case (t.p.sel)
      ITEM_CURRENT: begin
        ceil_v = ceiling(r.p.work, c);
        if (up && r.p.amps < ceil_v) begin
          r.p.amps = r.p.amps + 6'd1;
          r = value_redraw(r, ITEM_CURRENT);
          r = issue(r, ITEM_CURRENT, r.p.amps);
        end else if (!up && r.p.amps > c.cur_min) begin
          r.p.amps = r.p.amps - 6'd1;
          r = value_redraw(r, ITEM_CURRENT);
          r = issue(r, ITEM_CURRENT, r.p.amps);
        end
      end
      ITEM_TRIGGER: begin
        r.p.trig = ~r.p.trig;
        r = value_redraw(r, ITEM_TRIGGER);
        r = issue(r, ITEM_TRIGGER, {5'd0, r.p.trig});
      end
      ITEM_GAS: begin
        if ((up && r.p.gas < TIME_HI) || (!up && r.p.gas > TIME_LO)) begin
          r.p.gas = up ? r.p.gas + 4'd1 : r.p.gas - 4'd1;
          r = value_redraw(r, ITEM_GAS);
          r = issue(r, ITEM_GAS, {2'd0, r.p.gas});
        end
      end
      ITEM_ARC: begin
        if ((up && r.p.arc < TIME_HI) || (!up && r.p.arc > TIME_LO)) begin
          r.p.arc = up ? r.p.arc + 4'd1 : r.p.arc - 4'd1;
          r = value_redraw(r, ITEM_ARC);
          r = issue(r, ITEM_ARC, {2'd0, r.p.arc});
        end
      end
      default: begin
        r.p.work = up ? r.p.work + 2'd1 : r.p.work - 2'd1;
        ceil_v   = ceiling(r.p.work, c);
        if (r.p.amps > ceil_v) begin
          r.p.amps = ceil_v;
          r = value_redraw(r, ITEM_CURRENT);
        end
        r = value_redraw(r, ITEM_WORK);
        r = issue(r, ITEM_WORK, {4'd0, r.p.work});
        r = issue(r, ITEM_CURRENT, r.p.amps);
      end
    endcase
    return r;
  endfunction

endpackage

/* design/pkpe_in_if.sv */
interface pkpe_in_if;
  logic               valid;
  logic               ready;
  pkpe_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/pkpe_out_if.sv */
interface pkpe_out_if;
  logic                valid;
  logic                ready;
  pkpe_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/panel_keypad_parameter_editor_top.sv */
// Keypad parameter editor: each input beat is one keypad tick carrying four raw
// active-low key levels (up, down, left, right). A tick is captured in an input
// register, evaluated combinationally (debounce, auto-repeat, parameter edit) and
// its results are loaded into a result buffer that drains one output beat per
// cycle while the output is ready. A tick yields one beat when it issues no set
// command, else one beat per command (at most four); every beat carries the final
// parameter values and redraw mask, and the last one has last set. The next tick
// is taken in the cycle the previous tick's last beat leaves, and one more tick
// can wait in the input register meanwhile. An input beat passes through the input
// register and then the result buffer before its first output beat. Configuration
// writes land at once and are meant for idle periods only.
module panel_keypad_parameter_editor_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  pkpe_in_if.sink            in_i,
  pkpe_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);

  // Configuration registers
  pkpe_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pkpe_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (pkpe_pkg::reg_idx_e'(cfg_idx_i))
        pkpe_pkg::REG_CURRENT_MIN:           cfg_q.cur_min   <= cfg_data_i[5:0];
        pkpe_pkg::REG_CURRENT_MAX_HIGH_LINE: cfg_q.max_hi    <= cfg_data_i[5:0];
        pkpe_pkg::REG_CURRENT_MAX_LOW_LINE:  cfg_q.max_lo    <= cfg_data_i[5:0];
        pkpe_pkg::REG_CURRENT_MAX_LIMITED:   cfg_q.max_lim   <= cfg_data_i[5:0];
        pkpe_pkg::REG_LINE_IS_HIGH:          cfg_q.line_hi   <= cfg_data_i[0];
        pkpe_pkg::REG_DEBOUNCE_LIMIT:        cfg_q.deb_lim   <= cfg_data_i[3:0];
        pkpe_pkg::REG_REPEAT_START:          cfg_q.rep_start <= cfg_data_i;
        pkpe_pkg::REG_REPEAT_NEXT:           cfg_q.rep_next  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register and result buffer handshake
  logic               iv_q;
  pkpe_pkg::in_beat_t ilvl_q;
  logic               ob_valid_q;
  logic [1:0]         ob_idx_q;
  logic [1:0]         ob_last_q;
  logic               out_beat;
  logic               out_done;
  logic               load;

  assign out_beat = out_o.valid && out_o.ready;
  assign out_done = out_beat && (ob_idx_q == ob_last_q);
  // Evaluate the held tick once the buffer is empty or emptying this cycle
  assign load     = iv_q && (!ob_valid_q || out_done);
  assign in_i.ready = !iv_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      iv_q <= 1'b1;
    end else if (load) begin
      iv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ilvl_q <= in_i.data;
    end
  end

  // Editor state
  pkpe_pkg::prm_t prm_q;
  logic [3:0]     held_q, held_d;
  logic [3:0]     deb_q [4];
  logic [3:0]     deb_d [4];
  logic [7:0]     rep_q [2];
  logic [7:0]     rep_d [2];
  pkpe_pkg::tick_t tick;

  // One tick: up, down, left, right in that order, each seeing the ones before
  always_comb begin
    pkpe_pkg::deb_t dr;
    logic           lvl;
    logic           released;
    tick        = '0;
    tick.p      = prm_q;
    held_d      = held_q;
    deb_d       = deb_q;
    rep_d       = rep_q;

    dr = pkpe_pkg::debounce(ilvl_q.up_level, held_q[0], deb_q[0], cfg_q.deb_lim);
    held_d[0] = dr.held;
    deb_d[0]  = dr.cnt;
    if (dr.fire) begin
      tick = pkpe_pkg::move_sel(tick, 1'b0);
    end

    dr = pkpe_pkg::debounce(ilvl_q.down_level, held_q[1], deb_q[1], cfg_q.deb_lim);
    held_d[1] = dr.held;
    deb_d[1]  = dr.cnt;
    if (dr.fire) begin
      tick = pkpe_pkg::move_sel(tick, 1'b1);
    end

    // Left decreases, right increases; both auto-repeat while held
    for (int r = 0; r < 2; r++) begin
      lvl      = (r == 0) ? ilvl_q.left_level : ilvl_q.right_level;
      released = lvl;
      if (released) begin
        rep_d[r] = 8'd0;
      end
      dr = pkpe_pkg::debounce(lvl, held_q[r+2], deb_q[r+2], cfg_q.deb_lim);
      held_d[r+2] = dr.held;
      deb_d[r+2]  = dr.cnt;
      if (dr.fire) begin
        rep_d[r] = cfg_q.rep_start;
        tick = pkpe_pkg::adjust(tick, r == 1, cfg_q);
      end else if (!released && held_q[r+2]) begin
        if (rep_d[r] != 8'd0) begin
          rep_d[r] = rep_d[r] - 8'd1;
        end else begin
          rep_d[r] = cfg_q.rep_next;
          tick = pkpe_pkg::adjust(tick, r == 1, cfg_q);
        end
      end
    end
  end

  // Commit state only when the tick's results go into the buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prm_q  <= pkpe_pkg::PRM_RESET;
      held_q <= '0;
      deb_q  <= '{default: '0};
      rep_q  <= '{default: '0};
    end else if (load) begin
      prm_q  <= tick.p;
      held_q <= held_d;
      deb_q  <= deb_d;
      rep_q  <= rep_d;
    end
  end

  // Result buffer
  pkpe_pkg::prm_t            ob_prm_q;
  logic [13:0]               ob_mask_q;
  logic                      ob_has_cmd_q;
  logic [pkpe_pkg::MAX_CMDS-1:0][2:0] ob_codes_q;
  logic [pkpe_pkg::MAX_CMDS-1:0][5:0] ob_vals_q;
  logic [2:0]                ncmd_m1;

  assign ncmd_m1 = tick.ncmd - 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_valid_q <= 1'b0;
      ob_idx_q   <= 2'd0;
    end else if (load) begin
      ob_valid_q <= 1'b1;
      ob_idx_q   <= 2'd0;
    end else if (out_done) begin
      ob_valid_q <= 1'b0;
    end else if (out_beat) begin
      ob_idx_q <= ob_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_prm_q     <= tick.p;
      ob_mask_q    <= tick.mask;
      ob_has_cmd_q <= tick.ncmd != 3'd0;
      ob_last_q    <= (tick.ncmd == 3'd0) ? 2'd0 : ncmd_m1[1:0];
      ob_codes_q   <= tick.codes;
      ob_vals_q    <= tick.vals;
    end
  end

  assign out_o.valid = ob_valid_q;

  always_comb begin
    out_o.data.selected_item     = ob_prm_q.sel;
    out_o.data.current_amps      = ob_prm_q.amps;
    out_o.data.trigger_four_step = ob_prm_q.trig;
    out_o.data.post_gas_seconds  = ob_prm_q.gas;
    out_o.data.arc_seconds       = ob_prm_q.arc;
    out_o.data.work_kind         = ob_prm_q.work;
    out_o.data.redraw_mask       = ob_mask_q;
    out_o.data.cmd_valid         = ob_has_cmd_q;
    out_o.data.cmd_code          = ob_has_cmd_q ? ob_codes_q[ob_idx_q] : 3'd0;
    out_o.data.cmd_value         = ob_has_cmd_q ? ob_vals_q[ob_idx_q] : 6'd0;
    out_o.data.last              = ob_idx_q == ob_last_q;
  end

endmodule
